FILE: hw/rtl/rob_pkg.sv
// rob_pkg: shared constants, types and helpers of the per-sender reorder buffer
// used by the channel interfaces and every module of the block; depends on nothing
package rob_pkg;

	localparam int NUM_SENDERS = 8;
	localparam int WINDOW      = 32;
	localparam int SEQ_WIDTH   = 16;
	localparam int QUEUE_DEPTH = 2;

	// fixed field widths of the channels
	localparam int SENDER_W    = 3;
	localparam int SEQ_FIELD_W = 16;

	localparam int SIDX_W = $clog2(NUM_SENDERS);
	localparam int WIDX_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [SEQ_WIDTH-1:0]   seq_t;
	typedef logic [SEQ_FIELD_W-1:0] seq_field_t;
	typedef logic [SENDER_W-1:0]    sender_t;
	typedef logic [SIDX_W-1:0]      sidx_t;
	typedef logic [WINDOW-1:0]      map_t;
	typedef logic [WIDX_W-1:0]      widx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [QPTR_W-1:0]      qptr_t;
	typedef logic [QCNT_W-1:0]      qcnt_t;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_STALE   = 2'd1,
		KIND_BEYOND  = 2'd2
	} kind_t;

	// one command from front to back: a run of results of one sender
	typedef struct packed {
		kind_t   kind;
		sender_t sender;
		seq_t    seq;
		cnt_t    count;
	} cmd_t;

	// index of the set bit of a one-hot word
	function automatic widx_t onehot_index(map_t oh);
		widx_t idx;
		idx = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (oh[i]) begin
				idx = idx | widx_t'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: hw/rtl/rob_in_if.sv
// rob_in_if: input channel of the reorder buffer, one message per item
// depends on rob_pkg
interface rob_in_if;
	logic                 valid;
	logic                 ready;
	rob_pkg::sender_t     sender;
	rob_pkg::seq_field_t  seq_num;
	logic                 discard;

	modport source (output valid, sender, seq_num, discard, input ready);
	modport sink   (input valid, sender, seq_num, discard, output ready);
endinterface

FILE: hw/rtl/rob_out_if.sv
// rob_out_if: result channel of the reorder buffer, one delivery or drop per item
// depends on rob_pkg
interface rob_out_if;
	logic                 valid;
	logic                 ready;
	rob_pkg::kind_t       kind;
	rob_pkg::sender_t     out_sender;
	rob_pkg::seq_field_t  out_seq;
	logic                 last;

	modport source (output valid, kind, out_sender, out_seq, last, input ready);
	modport sink   (input valid, kind, out_sender, out_seq, last, output ready);
endinterface

FILE: hw/rtl/rob_front.sv
// rob_front: accepts messages, keeps per-sender expected number and pending map,
// classifies messages into commands unless only held as pending; depends on rob_pkg and rob_in_if
module rob_front (
	input  logic             clk,
	input  logic             arst_n,
	rob_in_if.sink           msg,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output rob_pkg::cmd_t    cmd
);

	logic                 s1_valid_q;
	rob_pkg::sender_t     s1_sender_s1;
	rob_pkg::seq_t        s1_seq_s1;

	rob_pkg::seq_t        next_q [rob_pkg::NUM_SENDERS];
	rob_pkg::map_t        pend_q [rob_pkg::NUM_SENDERS];

	rob_pkg::sidx_t       sidx;
	rob_pkg::seq_t        nx;
	rob_pkg::map_t        map;
	rob_pkg::seq_t        seq_dist;
	rob_pkg::map_t        zeros;
	rob_pkg::map_t        low_zero;
	rob_pkg::cnt_t        run;
	rob_pkg::map_t        hold_bit;
	logic                 in_win;
	logic                 need_cmd;
	logic                 upd_state;
	rob_pkg::seq_t        upd_nx;
	rob_pkg::map_t        upd_map;
	logic                 retire;
	logic                 in_range;

	assign sidx     = rob_pkg::sidx_t'(s1_sender_s1);
	assign nx       = next_q[sidx];
	assign map      = pend_q[sidx];
	assign seq_dist = s1_seq_s1 - nx;

	// run length: one plus the trailing ones above bit 0
	assign zeros    = ~(map >> 1);
	assign low_zero = zeros & (~zeros + rob_pkg::map_t'(1));
	assign run      = rob_pkg::cnt_t'(rob_pkg::onehot_index(low_zero)) + rob_pkg::cnt_t'(1);

	assign in_win   = !seq_dist[rob_pkg::SEQ_WIDTH-1] && (32'(seq_dist) < rob_pkg::WINDOW);
	assign hold_bit = rob_pkg::map_t'(1) << seq_dist[rob_pkg::WIDX_W-1:0];

	always_comb begin
		cmd        = '0;
		cmd.kind   = rob_pkg::KIND_STALE;
		cmd.sender = s1_sender_s1;
		cmd.seq    = s1_seq_s1;
		cmd.count  = rob_pkg::cnt_t'(1);
		need_cmd   = 1'b1;
		upd_state  = 1'b0;
		upd_nx     = nx;
		upd_map    = map;
		if (seq_dist == '0) begin
			cmd.kind  = rob_pkg::KIND_DELIVER;
			cmd.seq   = nx;
			cmd.count = run;
			upd_state = 1'b1;
			upd_nx    = nx + rob_pkg::seq_t'(run);
			upd_map   = map >> run;
		end else if (seq_dist[rob_pkg::SEQ_WIDTH-1]) begin
			cmd.kind = rob_pkg::KIND_STALE;
		end else if (in_win) begin
			if ((map & hold_bit) == '0) begin
				need_cmd  = 1'b0;
				upd_state = 1'b1;
				upd_map   = map | hold_bit;
			end
		end else begin
			cmd.kind = rob_pkg::KIND_BEYOND;
		end
	end

	assign cmd_valid = s1_valid_q && need_cmd;
	assign retire    = s1_valid_q && (!need_cmd || cmd_ready);
	assign msg.ready = !s1_valid_q || retire;
	assign in_range  = 32'(msg.sender) < rob_pkg::NUM_SENDERS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (msg.ready) begin
			s1_valid_q <= msg.valid && !msg.discard && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			s1_sender_s1 <= msg.sender;
			s1_seq_s1    <= rob_pkg::seq_t'(msg.seq_num);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < rob_pkg::NUM_SENDERS; s++) begin
				next_q[s] <= rob_pkg::seq_t'(1);
				pend_q[s] <= '0;
			end
		end else if (retire && upd_state) begin
			next_q[sidx] <= upd_nx;
			pend_q[sidx] <= upd_map;
		end
	end

	// slot of the expected number itself is never held
	a_bit0_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> !map[0])
		else $error("pending map holds the expected number");

endmodule

FILE: hw/rtl/rob_queue.sv
// rob_queue: short command queue between front and back
// depends on rob_pkg
module rob_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  rob_pkg::cmd_t    push_cmd,
	output logic             pop_valid,
	input  logic             pop_ready,
	output rob_pkg::cmd_t    pop_cmd
);

	rob_pkg::cmd_t  entry_q [rob_pkg::QUEUE_DEPTH];
	rob_pkg::qptr_t wr_ptr_q;
	rob_pkg::qptr_t rd_ptr_q;
	rob_pkg::qcnt_t count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = count_q != rob_pkg::qcnt_t'(rob_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic rob_pkg::qptr_t bump(rob_pkg::qptr_t p);
		return (32'(p) == rob_pkg::QUEUE_DEPTH - 1) ? '0 : p + rob_pkg::qptr_t'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + rob_pkg::qcnt_t'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - rob_pkg::qcnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= rob_pkg::QUEUE_DEPTH)
		else $error("command queue over capacity");

endmodule

FILE: hw/rtl/rob_back.sv
// rob_back: expands each command into result items, one per cycle while the result
// channel takes them, behind an output register; depends on rob_pkg and rob_out_if
module rob_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  rob_pkg::cmd_t    cmd,
	rob_out_if.source        res
);

	logic              cur_valid_q;
	rob_pkg::kind_t    cur_kind_q;
	rob_pkg::sender_t  cur_sender_q;
	rob_pkg::seq_t     cur_seq_q;
	rob_pkg::cnt_t     rem_q;

	logic              out_valid_q;
	rob_pkg::kind_t    out_kind_q;
	rob_pkg::sender_t  out_sender_q;
	rob_pkg::seq_t     out_seq_q;
	logic              out_last_q;

	logic              step;
	logic              final_step;

	assign step       = cur_valid_q && (!out_valid_q || res.ready);
	assign final_step = rem_q == rob_pkg::cnt_t'(1);
	assign cmd_ready  = !cur_valid_q || (step && final_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_ready) begin
				cur_valid_q <= cmd_valid;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cur_kind_q   <= cmd.kind;
			cur_sender_q <= cmd.sender;
			cur_seq_q    <= cmd.seq;
			rem_q        <= cmd.count;
		end else if (step) begin
			cur_seq_q <= cur_seq_q + rob_pkg::seq_t'(1);
			rem_q     <= rem_q - rob_pkg::cnt_t'(1);
		end
		if (step) begin
			out_kind_q   <= cur_kind_q;
			out_sender_q <= cur_sender_q;
			out_seq_q    <= cur_seq_q;
			out_last_q   <= final_step;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = out_kind_q;
	assign res.out_sender = out_sender_q;
	assign res.out_seq    = rob_pkg::seq_field_t'(out_seq_q);
	assign res.last       = out_last_q;

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> rem_q != '0)
		else $error("active command with no results left");

	a_drop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q != rob_pkg::KIND_DELIVER |-> out_last_q)
		else $error("drop report not marked last");

endmodule

FILE: hw/rtl/fifo_order_reorder_buffer.sv
// fifo_order_reorder_buffer: top level of the per-sender fifo reorder buffer
// depends on rob_pkg, rob_in_if, rob_out_if, rob_front, rob_queue, rob_back
// path: front stage register, command queue, back command register, output register
// throughput: front takes one item a cycle unless the command queue is full; back gives
//   one result a cycle while the result channel is ready
// reset: async, active low; every sender expects 1, all pending maps cleared at once
module fifo_order_reorder_buffer (
	input  logic       clk,
	input  logic       arst_n,
	rob_in_if.sink     msg,
	rob_out_if.source  res
);

	// front to queue
	logic           f_cmd_valid;
	logic           f_cmd_ready;
	rob_pkg::cmd_t  f_cmd;

	// queue to back
	logic           b_cmd_valid;
	logic           b_cmd_ready;
	rob_pkg::cmd_t  b_cmd;

	// front: one register stage, reads the sender's state and classifies
	// the message; state is written back when the item leaves the stage,
	// so a following item of the same sender sees the update
	rob_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.cmd_valid (f_cmd_valid),
		.cmd_ready (f_cmd_ready),
		.cmd       (f_cmd)
	);

	// decouples classification from result expansion
	rob_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_cmd_valid),
		.push_ready (f_cmd_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_cmd_valid),
		.pop_ready  (b_cmd_ready),
		.pop_cmd    (b_cmd)
	);

	// back: turns a delivery run or drop report into result items
	rob_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_cmd_valid),
		.cmd_ready (b_cmd_ready),
		.cmd       (b_cmd),
		.res       (res)
	);

endmodule
